>>> src/vector_distance_metric_defines.svh
// Assertion macros for the concurrent checks in vector_distance_metric.sv.
`ifndef VECTOR_DISTANCE_METRIC_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdm next-cycle check failed");

`endif

>>> src/vdm_pkg.sv
`default_nettype none
package vdm_pkg;

  localparam int unsigned MAX_DIMS = 1024;

  localparam logic [1:0] METRIC_EUCLID  = 2'd0;
  localparam logic [1:0] METRIC_MANHAT  = 2'd1;
  localparam logic [1:0] METRIC_CORR    = 2'd2;

  localparam logic [5:0] MUL_LAST_STEP  = 6'd3;
  localparam logic [5:0] SQRT_LAST_STEP = 6'd63;
  localparam logic [5:0] DIV_LAST_STEP  = 6'd23;

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam logic [39:0] DIST_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [23:0] x_value;
    logic signed [23:0] y_value;
    logic signed [23:0] center_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [39:0] distance;
    logic        undefined;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  metric;
    logic [63:0] cross_sum;
    logic [63:0] first_sum;
    logic [63:0] second_sum;
    logic        overflow;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DSET,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

>>> src/vector_distance_metric.sv
// Streaming vector distance. The input channel carries one dimension per
// transfer: an element of each vector, the dimension mean and a last flag.
// The 2-bit metric register picks Euclidean, Manhattan or correlation
// distance. The user must write it through cfg_we and cfg_wdata while the
// block idles; the block itself does not enforce this. Each input transfer
// passes a three-stage front end (differences, products, saturating sums),
// so the front end takes one transfer per cycle while in_stall is low. The
// transfer marked last places the finished sums in a two-entry queue. The
// back end then works on one vector at a time: Manhattan goes straight to
// the done state, Euclidean takes one square root bit per cycle over 64
// bits, and correlation takes 4 partial products, 64 root steps and up to
// 24 quotient steps. While the receiver stalls, the result holds in the
// output register, the back end may finish the next vector, and in_stall
// rises only when the queue is full and a last item waits. Synchronous
// reset clears the sums, the queue and out_valid and sets the metric to
// Euclidean.
`default_nettype none
`include "vector_distance_metric_defines.svh"
module vector_distance_metric (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire vdm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output vdm_pkg::out_item_t      out_data
);

  logic          [1:0] metric_r;
  logic                q_full, q_push, q_pop, q_not_empty;
  vdm_pkg::job_t       push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= vdm_pkg::METRIC_EUCLID;
    end else if (cfg_we) begin
      metric_r <= cfg_wdata;
    end
  end

  vdm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .metric   (metric_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  vdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  vdm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  `VDM_ASSERT_SAME(a_no_push_full, q_push, !q_full)
  `VDM_ASSERT_SAME(a_stall_only_full, in_stall, q_full)
  `VDM_ASSERT_SAME(a_undef_zero, out_valid && out_data.undefined, out_data.distance == 40'd0)
  `VDM_ASSERT_NEXT(a_pop_clears_full, q_pop && !q_push, !q_full)

endmodule
`default_nettype wire

>>> src/vdm_front.sv
`default_nettype none
module vdm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       metric,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire vdm_pkg::in_item_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output vdm_pkg::job_t         q_job
);

  logic               adv;
  logic               s1_valid_r, s1_last_r;
  logic [1:0]         s1_met_r;
  logic signed [24:0] s1_u_r, s1_v_r;
  logic               s2_valid_r, s2_last_r;
  logic [1:0]         s2_met_r;
  logic [49:0]        s2_p1_r, s2_p2_r;
  logic signed [49:0] s2_pc_r;
  logic [63:0]        first_r, second_r, cross_r;
  logic               ovf_r;

  logic signed [24:0] x_e, y_e, c_e, u_in, v_in, u_abs;
  logic signed [49:0] uu, vv, uv;
  logic [64:0]        f_sum, s_sum, c_sum;
  logic [63:0]        f_new, s_new, c_new;
  logic               c_ovf, ovf_new;

  assign adv      = !(s2_valid_r && s2_last_r && q_full);
  assign in_stall = !adv;

  assign x_e  = 25'(in_data.x_value);
  assign y_e  = 25'(in_data.y_value);
  assign c_e  = 25'(in_data.center_value);
  assign u_in = (metric == vdm_pkg::METRIC_CORR) ? (x_e - c_e) : (x_e - y_e);
  assign v_in = y_e - c_e;

  assign uu    = s1_u_r * s1_u_r;
  assign vv    = s1_v_r * s1_v_r;
  assign uv    = s1_u_r * s1_v_r;
  assign u_abs = s1_u_r[24] ? -s1_u_r : s1_u_r;

  assign f_sum   = {1'b0, first_r} + {15'd0, s2_p1_r};
  assign s_sum   = {1'b0, second_r} + {15'd0, s2_p2_r};
  assign c_sum   = {cross_r[63], cross_r} + {{15{s2_pc_r[49]}}, s2_pc_r};
  assign c_ovf   = c_sum[64] ^ c_sum[63];
  assign f_new   = f_sum[64] ? '1 : f_sum[63:0];
  assign s_new   = s_sum[64] ? '1 : s_sum[63:0];
  assign c_new   = c_ovf ? {c_sum[64], {63{~c_sum[64]}}} : c_sum[63:0];
  assign ovf_new = ovf_r | f_sum[64] | s_sum[64] | c_ovf;

  assign q_push           = adv && s2_valid_r && s2_last_r;
  assign q_job.metric     = s2_met_r;
  assign q_job.cross_sum  = c_new;
  assign q_job.first_sum  = f_new;
  assign q_job.second_sum = s_new;
  assign q_job.overflow   = ovf_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      first_r    <= '0;
      second_r   <= '0;
      cross_r    <= '0;
      ovf_r      <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s1_last_r  <= in_data.last;
      s1_met_r   <= metric;
      s1_u_r     <= u_in;
      s1_v_r     <= v_in;
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_last_r;
      s2_met_r   <= s1_met_r;
      case (s1_met_r)
        vdm_pkg::METRIC_EUCLID: begin
          s2_p1_r <= uu;
          s2_p2_r <= '0;
          s2_pc_r <= '0;
        end
        vdm_pkg::METRIC_MANHAT: begin
          s2_p1_r <= {25'd0, u_abs};
          s2_p2_r <= '0;
          s2_pc_r <= '0;
        end
        vdm_pkg::METRIC_CORR: begin
          s2_p1_r <= uu;
          s2_p2_r <= vv;
          s2_pc_r <= uv;
        end
        default: begin
          s2_p1_r <= '0;
          s2_p2_r <= '0;
          s2_pc_r <= '0;
        end
      endcase
      if (s2_valid_r) begin
        if (s2_last_r) begin
          first_r  <= '0;
          second_r <= '0;
          cross_r  <= '0;
          ovf_r    <= 1'b0;
        end else begin
          first_r  <= f_new;
          second_r <= s_new;
          cross_r  <= c_new;
          ovf_r    <= ovf_new;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/vdm_queue.sv
`default_nettype none
module vdm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vdm_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output vdm_pkg::job_t      head_job
);

  vdm_pkg::job_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> src/vdm_back.sv
`default_nettype none
module vdm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  wire vdm_pkg::job_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output vdm_pkg::out_item_t out_data
);

  vdm_pkg::back_state_t state_r, state_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  vdm_pkg::job_t      job_r, job_nxt;
  logic [127:0]       prod_r, prod_nxt;
  logic [63:0]        root_r, root_nxt;
  logic [64:0]        rem_r, rem_nxt;
  logic [24:0]        q_r, q_nxt;
  logic               out_valid_r, out_valid_nxt;
  vdm_pkg::out_item_t out_data_r, out_data_nxt;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [66:0]  sq_rem, sq_trial;
  logic         sq_ge;
  logic [64:0]  dv_rem;
  logic         dv_ge;
  logic [63:0]  mag;

  assign a_half   = cnt_r[1] ? job_r.first_sum[63:32] : job_r.first_sum[31:0];
  assign b_half   = cnt_r[0] ? job_r.second_sum[63:32] : job_r.second_sum[31:0];
  assign pp       = a_half * b_half;
  assign sh       = {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'd0};
  assign sq_rem   = {rem_r, prod_r[127:126]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_rem >= sq_trial);
  assign dv_rem   = {rem_r[63:0], 1'b0};
  assign dv_ge    = (dv_rem >= {1'b0, root_r});
  assign mag      = job_r.cross_sum[63] ? (64'd0 - job_r.cross_sum) : job_r.cross_sum;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    job_r      <= job_nxt;
    prod_r     <= prod_nxt;
    root_r     <= root_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    job_nxt       = job_r;
    prod_nxt      = prod_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    case (state_r)
      vdm_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          q_pop    = 1'b1;
          job_nxt  = q_head;
          cnt_nxt  = '0;
          root_nxt = '0;
          rem_nxt  = '0;
          case (q_head.metric)
            vdm_pkg::METRIC_CORR: begin
              prod_nxt  = '0;
              state_nxt = vdm_pkg::ST_MUL;
            end
            vdm_pkg::METRIC_EUCLID: begin
              prod_nxt  = {64'd0, q_head.first_sum};
              state_nxt = vdm_pkg::ST_SQRT;
            end
            default: begin
              state_nxt = vdm_pkg::ST_DONE;
            end
          endcase
        end
      end
      vdm_pkg::ST_MUL: begin
        prod_nxt = prod_r + ({64'd0, pp} << sh);
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == vdm_pkg::MUL_LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = vdm_pkg::ST_SQRT;
        end
      end
      vdm_pkg::ST_SQRT: begin
        rem_nxt  = sq_ge ? 65'(sq_rem - sq_trial) : sq_rem[64:0];
        root_nxt = {root_r[62:0], sq_ge};
        prod_nxt = {prod_r[125:0], 2'b00};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == vdm_pkg::SQRT_LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = (job_r.metric == vdm_pkg::METRIC_CORR) ? vdm_pkg::ST_DSET
                                                             : vdm_pkg::ST_DONE;
        end
      end
      vdm_pkg::ST_DSET: begin
        if (root_r == 64'd0) begin
          state_nxt = vdm_pkg::ST_DONE;
        end else if (mag >= root_r) begin
          q_nxt     = vdm_pkg::ONE_Q24;
          state_nxt = vdm_pkg::ST_DONE;
        end else begin
          q_nxt     = '0;
          rem_nxt   = {1'b0, mag};
          cnt_nxt   = '0;
          state_nxt = vdm_pkg::ST_DIV;
        end
      end
      vdm_pkg::ST_DIV: begin
        rem_nxt = dv_ge ? (dv_rem - {1'b0, root_r}) : dv_rem;
        q_nxt   = {q_r[23:0], dv_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == vdm_pkg::DIV_LAST_STEP) begin
          state_nxt = vdm_pkg::ST_DONE;
        end
      end
      vdm_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.undefined = 1'b0;
          out_data_nxt.saturated = job_r.overflow;
          out_data_nxt.distance  = '0;
          case (job_r.metric)
            vdm_pkg::METRIC_EUCLID: begin
              out_data_nxt.distance = root_r[39:0];
            end
            vdm_pkg::METRIC_MANHAT: begin
              if (job_r.first_sum[63:40] != 24'd0) begin
                out_data_nxt.distance  = vdm_pkg::DIST_MAX;
                out_data_nxt.saturated = 1'b1;
              end else begin
                out_data_nxt.distance = job_r.first_sum[39:0];
              end
            end
            vdm_pkg::METRIC_CORR: begin
              if (root_r == 64'd0) begin
                out_data_nxt.undefined = 1'b1;
              end else if (job_r.cross_sum[63]) begin
                out_data_nxt.distance = {14'd0, {1'b0, vdm_pkg::ONE_Q24} + {1'b0, q_r}};
              end else begin
                out_data_nxt.distance = {15'd0, vdm_pkg::ONE_Q24 - q_r};
              end
            end
            default: begin
              out_data_nxt.distance = '0;
            end
          endcase
          state_nxt = vdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vdm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> dv/tb_vector_distance_metric.sv
`default_nettype none
module tb_vector_distance_metric;

  localparam logic [1:0] METRIC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_DIMS = 1030;

  class distance_scoreboard;
    vdm_pkg::out_item_t expected_q[$];
    logic [1:0] metric;
    logic [63:0] cross_acc;
    logic [63:0] first_acc;
    logic [63:0] second_acc;
    logic sat_seen;
    int errors;
    int checked;
    int vectors[4];
    int saturated_count;
    int undefined_count;

    function new();
      metric = vdm_pkg::METRIC_EUCLID;
      cross_acc = '0;
      first_acc = '0;
      second_acc = '0;
      sat_seen = 1'b0;
      errors = 0;
      checked = 0;
      saturated_count = 0;
      undefined_count = 0;
      foreach (vectors[i]) vectors[i] = 0;
    endfunction

    function logic [63:0] add_unsigned(logic [63:0] acc, logic [63:0] inc);
      logic [64:0] s;
      s = {1'b0, acc} + {1'b0, inc};
      if (s[64]) begin
        sat_seen = 1'b1;
        return '1;
      end
      return s[63:0];
    endfunction

    function logic [63:0] add_signed(logic [63:0] acc, longint p);
      longint a;
      longint s;
      a = acc;
      s = a + p;
      if (a[63] == p[63] && s[63] != a[63]) begin
        sat_seen = 1'b1;
        return p[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
    endfunction

    function logic [63:0] root128(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      logic [127:0] cc;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        cc = {64'd0, c} * {64'd0, c};
        if (cc <= v) r = c;
      end
      return r;
    endfunction

    function vdm_pkg::out_item_t finish_vector();
      vdm_pkg::out_item_t e;
      logic [127:0] prod;
      logic [63:0] s;
      logic [63:0] m;
      logic [63:0] rem;
      logic [24:0] q;
      logic neg;
      logic carry;
      e = '0;
      case (metric)
        vdm_pkg::METRIC_EUCLID: e.distance = root128({64'd0, first_acc}) & vdm_pkg::DIST_MAX;
        vdm_pkg::METRIC_MANHAT: begin
          if (first_acc > {24'd0, vdm_pkg::DIST_MAX}) begin
            e.distance = vdm_pkg::DIST_MAX;
            sat_seen = 1'b1;
          end else begin
            e.distance = first_acc[39:0];
          end
        end
        vdm_pkg::METRIC_CORR: begin
          prod = {64'd0, first_acc} * {64'd0, second_acc};
          s = root128(prod);
          if (s == 0) begin
            e.undefined = 1'b1;
          end else begin
            neg = cross_acc[63];
            m = neg ? -cross_acc : cross_acc;
            if (m >= s) begin
              q = vdm_pkg::ONE_Q24;
            end else begin
              rem = m;
              q = '0;
              for (int i = 0; i < 24; i++) begin
                carry = rem[63];
                rem = rem << 1;
                q = q << 1;
                if (carry || rem >= s) begin
                  rem = rem - s;
                  q[0] = 1'b1;
                end
              end
            end
            e.distance = neg ? 40'(vdm_pkg::ONE_Q24) + 40'(q)
                             : 40'(vdm_pkg::ONE_Q24) - 40'(q);
          end
        end
        default: e.distance = '0;
      endcase
      e.saturated = sat_seen;
      vectors[metric]++;
      if (e.saturated) saturated_count++;
      if (e.undefined) undefined_count++;
      cross_acc = '0;
      first_acc = '0;
      second_acc = '0;
      sat_seen = 1'b0;
      return e;
    endfunction

    function void note_input(vdm_pkg::in_item_t it);
      longint x;
      longint y;
      longint c;
      longint d;
      longint cx;
      longint cy;
      x = it.x_value;
      y = it.y_value;
      c = it.center_value;
      case (metric)
        vdm_pkg::METRIC_EUCLID: begin
          d = x - y;
          first_acc = add_unsigned(first_acc, d * d);
        end
        vdm_pkg::METRIC_MANHAT: begin
          d = x - y;
          if (d < 0) d = -d;
          first_acc = add_unsigned(first_acc, d);
        end
        vdm_pkg::METRIC_CORR: begin
          cx = x - c;
          cy = y - c;
          cross_acc = add_signed(cross_acc, cx * cy);
          first_acc = add_unsigned(first_acc, cx * cx);
          second_acc = add_unsigned(second_acc, cy * cy);
        end
        default: ;
      endcase
      if (it.last) expected_q.push_back(finish_vector());
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(vdm_pkg::out_item_t got);
      vdm_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, distance %0d",
                                  got.distance));
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (got.distance !== e.distance)
          report_mismatch($sformatf("distance %0d, expected %0d", got.distance, e.distance));
        if (got.undefined !== e.undefined)
          report_mismatch($sformatf("undefined %b, expected %b", got.undefined, e.undefined));
        if (got.saturated !== e.saturated)
          report_mismatch($sformatf("saturated %b, expected %b", got.saturated, e.saturated));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  vdm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vdm_pkg::out_item_t out_data;

  distance_scoreboard sb = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_wait = 0;
  int cycles = 0;
  int sent = 0;

  vector_distance_metric u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: a fresh stall length is drawn after every transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 7);
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task push(logic [23:0] x, logic [23:0] y, logic [23:0] c, logic last, bit no_gap);
    vdm_pkg::in_item_t it;
    int gap;
    it.x_value = x;
    it.y_value = y;
    it.center_value = c;
    it.last = last;
    gap = (tx_quiet || no_gap) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_metric(logic [1:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    sb.metric = m;
    cfg_we <= 1'b0;
  endtask

  function logic [23:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 8192)) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  task long_vector(logic [1:0] m);
    write_metric(m);
    for (int i = 0; i < LONG_DIMS; i++)
      push(24'h7FFFFF, 24'h800000, 24'h800000, i == LONG_DIMS - 1, 1'b1);
    drain();
  endtask

  initial begin
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] c;
    logic [1:0] phase_metric[12];
    int len;
    int phase_items;
    bit flat;

    phase_metric = '{vdm_pkg::METRIC_EUCLID, vdm_pkg::METRIC_MANHAT, vdm_pkg::METRIC_CORR,
                     METRIC_UNUSED, vdm_pkg::METRIC_CORR, vdm_pkg::METRIC_EUCLID,
                     vdm_pkg::METRIC_MANHAT, vdm_pkg::METRIC_CORR, METRIC_UNUSED,
                     vdm_pkg::METRIC_MANHAT, vdm_pkg::METRIC_CORR, vdm_pkg::METRIC_EUCLID};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset metric is Euclidean.
    push(24'h7FFFFF, 24'h800000, 24'h0, 1'b0, 1'b0);
    push(24'h000000, 24'h000000, 24'h0, 1'b1, 1'b0);
    push(24'h000001, 24'h000000, 24'h0, 1'b1, 1'b0);
    drain();
    write_metric(vdm_pkg::METRIC_MANHAT);
    push(24'h800000, 24'h7FFFFF, 24'h0, 1'b0, 1'b0);
    push(24'h000123, 24'hFFF000, 24'h0, 1'b1, 1'b0);
    drain();
    write_metric(vdm_pkg::METRIC_CORR);
    push(24'h001000, 24'h002000, 24'h000000, 1'b1, 1'b0);
    push(24'h001000, 24'hFFF000, 24'h000000, 1'b0, 1'b0);
    push(24'hFFF000, 24'h001000, 24'h000000, 1'b1, 1'b0);
    push(24'h000500, 24'h7FFFFF, 24'h000500, 1'b0, 1'b0);
    push(24'h000500, 24'h800000, 24'h000500, 1'b1, 1'b0);
    push(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    push(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
    push(24'h000010, 24'h000030, 24'h000020, 1'b1, 1'b0);
    drain();
    write_metric(METRIC_UNUSED);
    push(24'h7FFFFF, 24'h800000, 24'h123456, 1'b0, 1'b0);
    push(24'h000001, 24'h000002, 24'h000003, 1'b1, 1'b0);
    drain();

    // The metric changes while a vector is only partly in.
    write_metric(vdm_pkg::METRIC_EUCLID);
    push(24'h001000, 24'h000000, 24'h000000, 1'b0, 1'b0);
    push(24'h002000, 24'h000000, 24'h000000, 1'b0, 1'b0);
    drain();
    write_metric(vdm_pkg::METRIC_CORR);
    push(24'h003000, 24'h001000, 24'h000000, 1'b1, 1'b0);
    drain();
    write_metric(vdm_pkg::METRIC_MANHAT);
    push(24'h004000, 24'h000000, 24'h000000, 1'b0, 1'b0);
    drain();
    write_metric(vdm_pkg::METRIC_EUCLID);
    push(24'h001000, 24'h000000, 24'h000000, 1'b1, 1'b0);
    drain();

    // One vector longer than the nominal dimension limit.
    long_vector(vdm_pkg::METRIC_EUCLID);

    foreach (phase_metric[p]) begin
      write_metric(phase_metric[p]);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < 24) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        flat = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          x = pick_value();
          y = pick_value();
          c = flat ? x : pick_value();
          push(x, y, c, i == len - 1, 1'b0);
        end
        phase_items += len;
      end
      drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    $display("Sent %0d transfers; checked %0d distances (Euclidean %0d, Manhattan %0d,",
             sent, sb.checked, sb.vectors[vdm_pkg::METRIC_EUCLID],
             sb.vectors[vdm_pkg::METRIC_MANHAT]);
    $display("correlation %0d, unused metric %0d), %0d saturated, %0d undefined.",
             sb.vectors[vdm_pkg::METRIC_CORR], sb.vectors[METRIC_UNUSED], sb.saturated_count,
             sb.undefined_count);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
